[rtl/core/assert_macros.svh]
// assertion macros used by the checker file wrs_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define WRS_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define WRS_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

[rtl/core/wrs_pkg.sv]
// types, widths and codes for the weighted roulette selector
// no dependencies
package wrs_pkg;

	localparam int DEPTH    = 64;
	localparam int ID_W     = 16;
	localparam int WEIGHT_W = 20;
	localparam int SUM_W    = 26;
	localparam int COUNT_W  = 7;
	localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int ACC_W    = WEIGHT_W + IDX_W;
	localparam int CMP_W    = (ACC_W > SUM_W) ? ACC_W : SUM_W;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_SELECT = 2'd1,
		FN_CLEAR  = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		CM_HOLD,
		CM_INSERT,
		CM_ROTATE
	} cell_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic [WEIGHT_W-1:0] weight;
	} entry_t;

	typedef struct packed {
		cell_mode_t          mode;
		logic [ID_W-1:0]     id;
		logic [WEIGHT_W-1:0] weight;
	} cell_ctl_t;

endpackage

[rtl/core/wrs_cell.sv]
// one table slot of the sorted chain: holds an entry, shifts on insert, rotates on walk
// depends on wrs_pkg
module wrs_cell
	import wrs_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occupied,
	input  logic      prev_keep,
	input  entry_t    prev_entry,
	input  entry_t    next_entry,
	output logic      keep,
	output entry_t    entry
);

	entry_t entry_q;

	// slot stays put when it outranks or ties the new weight
	assign keep  = occupied && (entry_q.weight >= ctl.weight);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		case (ctl.mode)
			CM_INSERT: begin
				if (!keep) begin
					if (prev_keep) begin
						entry_q <= '{id: ctl.id, weight: ctl.weight};
					end else begin
						entry_q <= prev_entry;
					end
				end
			end
			CM_ROTATE: begin
				entry_q <= next_entry;
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule

[rtl/core/weighted_roulette_select.sv]
// top level of the weighted roulette selector: control, totals and the cell chain
// depends on wrs_pkg and wrs_cell
//
// channel   direction  handshake              payload
// request   in         req_valid / req_ready  func, item_id, item_weight, target
// result    out        rsp_valid / rsp_ready  chosen_id, chosen_weight, found, status,
//                                             total_weight, entry_count
//
// insert, clear and the unused code pass through the exec and final states to the result
// select walks instead: the chain rotates once, one slot past the head per cycle
// one request in flight; a new request is taken while the last result still waits
// reset clears count, total and handshake state; the table holds no reset value
// a stalled result holds the control in its final state until the slot frees
module weighted_roulette_select
	import wrs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [1:0]          func,
	input  logic [ID_W-1:0]     item_id,
	input  logic [WEIGHT_W-1:0] item_weight,
	input  logic [SUM_W-1:0]    target,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [ID_W-1:0]     chosen_id,
	output logic [WEIGHT_W-1:0] chosen_weight,
	output logic                found,
	output logic                status,
	output logic [SUM_W-1:0]    total_weight,
	output logic [COUNT_W-1:0]  entry_count
);

	state_t state_q, state_nx;

	// latched request
	func_t               func_q;
	logic [ID_W-1:0]     id_q;
	logic [WEIGHT_W-1:0] wt_q;
	logic [SUM_W-1:0]    tgt_q;

	// architectural state
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;

	// walk state
	logic [IDX_W-1:0] step_q;
	logic [ACC_W-1:0] acc_q;
	logic             hit_q;
	entry_t           hit_entry_q;
	logic             status_q;

	// result register
	logic                rsp_valid_q;
	logic [ID_W-1:0]     chosen_id_q;
	logic [WEIGHT_W-1:0] chosen_weight_q;
	logic                found_q;
	logic                status_out_q;
	logic [SUM_W-1:0]    total_q;
	logic [COUNT_W-1:0]  entry_count_q;

	// chain wiring
	cell_ctl_t  ctl;
	entry_t     entries [DEPTH];
	logic       keeps   [DEPTH];

	logic             req_take;
	logic             full;
	logic             do_insert;
	logic             slot_free;
	logic             head_occ;
	logic [ACC_W-1:0] acc_nx;
	logic [SUM_W:0]   sum_ext;

	assign req_take  = req_valid && req_ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign do_insert = (state_q == ST_EXEC) && (func_q == FN_INSERT) && !full;
	assign slot_free = !rsp_valid_q || rsp_ready;

	// the slot at the head of the chain is the walk's current entry
	assign head_occ = (CNT_W'(step_q) < count_q);
	assign acc_nx   = acc_q + ACC_W'(entries[0].weight);
	assign sum_ext  = {1'b0, sum_q} + (SUM_W + 1)'(wt_q);

	// next state and chain command
	always_comb begin
		state_nx   = state_q;
		req_ready  = 1'b0;
		ctl.mode   = CM_HOLD;
		ctl.id     = id_q;
		ctl.weight = wt_q;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (func_t'(func) == FN_SELECT) begin
						state_nx = ST_WALK;
					end else begin
						state_nx = ST_EXEC;
					end
				end
			end
			ST_EXEC: begin
				if (do_insert) begin
					ctl.mode = CM_INSERT;
				end
				state_nx = ST_FIN;
			end
			ST_WALK: begin
				ctl.mode = CM_ROTATE;
				if (step_q == IDX_W'(DEPTH - 1)) begin
					state_nx = ST_FIN;
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (req_take) begin
			func_q <= func_t'(func);
			id_q   <= item_id;
			wt_q   <= item_weight;
			tgt_q  <= target;
		end
	end

	// count and running total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (state_q == ST_EXEC) begin
			if (do_insert) begin
				count_q <= count_q + CNT_W'(1);
				// saturate the total at its full-scale value
				sum_q   <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
			end else if (func_q == FN_CLEAR) begin
				count_q <= '0;
				sum_q   <= '0;
			end
		end
	end

	// walk bookkeeping: accumulate head weights and keep the first hit
	always_ff @(posedge clk) begin
		if (req_take) begin
			step_q   <= '0;
			acc_q    <= '0;
			hit_q    <= 1'b0;
			status_q <= 1'b0;
		end else if (state_q == ST_EXEC) begin
			status_q <= (func_q == FN_INSERT) && full;
		end else if (state_q == ST_WALK) begin
			step_q <= step_q + IDX_W'(1);
			acc_q  <= acc_nx;
			if (!hit_q && head_occ && (CMP_W'(acc_nx) >= CMP_W'(tgt_q))) begin
				hit_q       <= 1'b1;
				hit_entry_q <= entries[0];
			end
		end
	end

	// result register, loaded when the output slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && slot_free) begin
			if (func_q == FN_SELECT && hit_q) begin
				chosen_id_q     <= hit_entry_q.id;
				chosen_weight_q <= hit_entry_q.weight;
				found_q         <= 1'b1;
			end else begin
				chosen_id_q     <= '0;
				chosen_weight_q <= '0;
				found_q         <= 1'b0;
			end
			status_out_q  <= (func_q == FN_INSERT) && status_q;
			total_q       <= sum_q;
			entry_count_q <= COUNT_W'(count_q);
		end
	end

	// the chain: slot 0 holds the heaviest entry, ties go after earlier ones
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   occ;
		logic   prev_keep;
		entry_t prev_entry;

		assign occ = (CNT_W'(i) < count_q);
		if (i == 0) begin : g_head
			assign prev_keep  = 1'b1;
			assign prev_entry = entries[0];
		end else begin : g_body
			assign prev_keep  = keeps[i-1];
			assign prev_entry = entries[i-1];
		end

		wrs_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (occ),
			.prev_keep  (prev_keep),
			.prev_entry (prev_entry),
			.next_entry (entries[(i + 1) % DEPTH]),
			.keep       (keeps[i]),
			.entry      (entries[i])
		);
	end

	assign rsp_valid     = rsp_valid_q;
	assign chosen_id     = chosen_id_q;
	assign chosen_weight = chosen_weight_q;
	assign found         = found_q;
	assign status        = status_out_q;
	assign total_weight  = total_q;
	assign entry_count   = entry_count_q;

endmodule

[rtl/core/wrs_checker.sv]
// port-level checks for the weighted roulette selector, bound to the top level
// depends on wrs_pkg and assert_macros.svh
`include "assert_macros.svh"

module wrs_checker
	import wrs_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic [1:0]          func,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [ID_W-1:0]     chosen_id,
	input logic [WEIGHT_W-1:0] chosen_weight,
	input logic                found,
	input logic                status
);

	// a request left waiting keeps its function code
	`WRS_ASSERT_NEXT(a_req_hold, clk, arst_n, req_valid && !req_ready, $stable(func))

	// a stalled result keeps its selection
	`WRS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(chosen_id))

	// no hit reports an all-zero entry
	`WRS_ASSERT_IMPLY(a_miss_zero, clk, arst_n, rsp_valid && !found, chosen_id == '0 && chosen_weight == '0)

	// a dropped insert never carries a selection
	`WRS_ASSERT_IMPLY(a_drop_excl, clk, arst_n, rsp_valid && status, !found)

endmodule

bind weighted_roulette_select wrs_checker u_wrs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req_valid),
	.req_ready     (req_ready),
	.func          (func),
	.rsp_valid     (rsp_valid),
	.rsp_ready     (rsp_ready),
	.chosen_id     (chosen_id),
	.chosen_weight (chosen_weight),
	.found         (found),
	.status        (status)
);
